// ===== design/pid_pkg.sv =====
// ----------------------------------------------------------------------------
// PID step package
// Shared types and constants for the discrete PID step block.
// ----------------------------------------------------------------------------
package pid_pkg;

    // Field widths fixed by the item format.
    localparam int ERR_W   = 16;
    localparam int DIFF_W  = 17;
    localparam int SUM_W   = 32;
    localparam int GAIN_W  = 16;
    localparam int DRIVE_W = 32;
    localparam int TOTAL_W = 48;
    localparam int SQ_W    = 31;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // Item opcodes.
    typedef enum logic [1:0] {
        OP_SAMPLE  = 2'd0,
        OP_RESTART = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_NONE    = 2'd3
    } t_opcode;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_KP     = 2'd0,
        CFG_KD     = 2'd1,
        CFG_KI     = 2'd2,
        CFG_RECORD = 2'd3
    } t_cfg_reg;

    // Current gains and recording flag.
    typedef struct packed {
        logic signed [GAIN_W-1:0] kp;
        logic signed [GAIN_W-1:0] kd;
        logic signed [GAIN_W-1:0] ki;
        logic                     record;
    } t_cfg;

    // Classified work request handed from the front end to the back end.
    typedef struct packed {
        t_opcode                  op;
        logic signed [ERR_W-1:0]  err;
        logic signed [DIFF_W-1:0] diff;
        logic signed [SUM_W-1:0]  sum;
        logic                     int_hit;
    } t_work;

    // Finished result.
    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic [TOTAL_W-1:0]        total;
        logic                      saturated;
    } t_result;

endpackage

// ===== design/pid_fifo.sv =====
// ----------------------------------------------------------------------------
// PID request queue
// Small first-in first-out queue in flip-flops with full and empty flags.
// ----------------------------------------------------------------------------
module pid_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr;
    logic [AW-1:0]    r_rptr;
    logic [CW-1:0]    r_count;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    // Storage; no reset needed on the payload.
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push_ok) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (pop_ok) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== design/pid_front.sv =====
// ----------------------------------------------------------------------------
// PID front end
// Accepts items, keeps the previous error and the integral sum, and hands
// a classified work request to the back end.
// ----------------------------------------------------------------------------
module pid_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    input  logic [1:0]                        i_opcode,
    input  logic signed [pid_pkg::ERR_W-1:0]  i_error_sample,
    input  logic                              i_queue_full,
    output logic                              o_queue_push,
    output pid_pkg::t_work                    o_work
);

    localparam logic signed [pid_pkg::SUM_W:0] SUM_HI = 33'sd2147483647;
    localparam logic signed [pid_pkg::SUM_W:0] SUM_LO = -33'sd2147483648;

    logic signed [pid_pkg::ERR_W-1:0]  r_prev;
    logic signed [pid_pkg::SUM_W-1:0]  r_sum;
    logic signed [pid_pkg::ERR_W-1:0]  n_prev;
    logic signed [pid_pkg::SUM_W-1:0]  n_sum;
    logic signed [pid_pkg::SUM_W:0]    sum_wide;
    logic signed [pid_pkg::SUM_W-1:0]  sum_sat;
    logic                              sum_hit;
    pid_pkg::t_opcode                  op;
    logic                              accept;

    assign op     = pid_pkg::t_opcode'(i_opcode);
    assign accept = i_push && !i_queue_full;

    // Saturating integral update with the new error.
    always_comb begin
        sum_wide = (pid_pkg::SUM_W + 1)'(r_sum) + (pid_pkg::SUM_W + 1)'(i_error_sample);
        sum_hit  = 1'b0;
        if (sum_wide > SUM_HI) begin
            sum_sat = pid_pkg::SUM_W'(SUM_HI);
            sum_hit = 1'b1;
        end else if (sum_wide < SUM_LO) begin
            sum_sat = pid_pkg::SUM_W'(SUM_LO);
            sum_hit = 1'b1;
        end else begin
            sum_sat = sum_wide[pid_pkg::SUM_W-1:0];
        end
    end

    // Next state by opcode.
    always_comb begin
        n_prev = r_prev;
        n_sum  = r_sum;
        unique case (op)
            pid_pkg::OP_SAMPLE: begin
                n_prev = i_error_sample;
                n_sum  = sum_sat;
            end
            pid_pkg::OP_RESTART: begin
                n_prev = i_error_sample;
                n_sum  = '0;
            end
            pid_pkg::OP_CLEAR: begin
                n_sum = '0;
            end
            pid_pkg::OP_NONE: begin
            end
        endcase
    end

    // Work request for the back end.
    always_comb begin
        o_queue_push   = accept;
        o_work.op      = op;
        o_work.err     = i_error_sample;
        o_work.diff    = pid_pkg::DIFF_W'(i_error_sample) - pid_pkg::DIFF_W'(r_prev);
        o_work.sum     = n_sum;
        o_work.int_hit = (op == pid_pkg::OP_SAMPLE) && sum_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_sum  <= '0;
        end else if (accept) begin
            r_prev <= n_prev;
            r_sum  <= n_sum;
        end
    end

endmodule

// ===== design/pid_back.sv =====
// ----------------------------------------------------------------------------
// PID back end
// Two-stage pipeline: gain products and square, then the term sum and the
// squared error total; the drive is negated and clamped on the way out.
// ----------------------------------------------------------------------------
module pid_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pid_pkg::t_cfg       i_cfg,
    input  pid_pkg::t_work      i_work,
    input  logic                i_queue_empty,
    output logic                o_queue_pop,
    input  logic                i_out_full,
    output logic                o_out_push,
    output pid_pkg::t_result    o_result
);

    localparam int ACC_W = 49;
    localparam int NEG_W = ACC_W + 1;
    localparam logic signed [NEG_W-1:0] DRIVE_HI = 50'sd2147483647;
    localparam logic signed [NEG_W-1:0] DRIVE_LO = -50'sd2147483648;

    logic                                  advance;
    logic signed [2*pid_pkg::ERR_W-1:0]    sq_full;

    // Stage one registers.
    logic                                  r1_valid;
    pid_pkg::t_opcode                      r1_op;
    logic signed [31:0]                    r1_prop;
    logic signed [32:0]                    r1_deriv;
    logic signed [47:0]                    r1_integ;
    logic [pid_pkg::SQ_W-1:0]              r1_sq;
    logic                                  r1_int_hit;

    // Stage two registers.
    logic                                  r2_valid;
    pid_pkg::t_opcode                      r2_op;
    logic signed [ACC_W-1:0]               r2_acc;
    logic [pid_pkg::TOTAL_W-1:0]           r2_total;
    logic                                  r2_int_hit;
    logic [pid_pkg::TOTAL_W-1:0]           r_total;
    logic [pid_pkg::TOTAL_W-1:0]           n_total;
    logic [pid_pkg::TOTAL_W:0]             total_wide;
    logic signed [ACC_W-1:0]               acc;
    logic signed [NEG_W-1:0]               neg;

    // The whole pipeline moves whenever the result queue has room.
    assign advance     = !i_out_full;
    assign o_queue_pop = advance && !i_queue_empty;
    assign sq_full     = i_work.err * i_work.err;

    // Stage one: the three gain products and the square of the error.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r1_op      <= i_work.op;
            r1_prop    <= 32'(i_cfg.kp * i_work.err);
            r1_deriv   <= 33'(i_cfg.kd * i_work.diff);
            r1_integ   <= 48'(i_cfg.ki * i_work.sum);
            r1_sq      <= sq_full[pid_pkg::SQ_W-1:0];
            r1_int_hit <= i_work.int_hit;
        end
    end

    // Term sum and saturating squared error total.
    always_comb begin
        acc        = ACC_W'(r1_prop) + ACC_W'(r1_deriv) + ACC_W'(r1_integ);
        total_wide = {1'b0, r_total} + (pid_pkg::TOTAL_W + 1)'(r1_sq);
        n_total    = r_total;
        unique case (r1_op)
            pid_pkg::OP_SAMPLE: begin
                if (i_cfg.record) begin
                    n_total = total_wide[pid_pkg::TOTAL_W] ? pid_pkg::TOTAL_MAX
                                                           : total_wide[pid_pkg::TOTAL_W-1:0];
                end
            end
            pid_pkg::OP_RESTART: begin
                n_total = '0;
            end
            pid_pkg::OP_CLEAR, pid_pkg::OP_NONE: begin
            end
        endcase
    end

    // Stage two payload.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r2_op      <= r1_op;
            r2_acc     <= acc;
            r2_total   <= n_total;
            r2_int_hit <= r1_int_hit;
        end
    end

    // Valid bits and the running total.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r_total  <= '0;
        end else if (advance) begin
            r1_valid <= o_queue_pop;
            r2_valid <= r1_valid;
            if (r1_valid) begin
                r_total <= n_total;
            end
        end
    end

    // Negate and clamp the drive; non-sample items show a zero drive and no saturation.
    always_comb begin
        neg                = -NEG_W'(r2_acc);
        o_out_push         = advance && r2_valid;
        o_result.total     = r2_total;
        o_result.drive     = '0;
        o_result.saturated = 1'b0;
        if (r2_op == pid_pkg::OP_SAMPLE) begin
            o_result.saturated = r2_int_hit;
            if (neg > DRIVE_HI) begin
                o_result.drive     = pid_pkg::DRIVE_W'(DRIVE_HI);
                o_result.saturated = 1'b1;
            end else if (neg < DRIVE_LO) begin
                o_result.drive     = pid_pkg::DRIVE_W'(DRIVE_LO);
                o_result.saturated = 1'b1;
            end else begin
                o_result.drive = neg[pid_pkg::DRIVE_W-1:0];
            end
        end
    end

endmodule

// ===== design/pid_controller_step_top.sv =====
// ----------------------------------------------------------------------------
// Discrete PID step, top level
// One request per clock while the request queue has room; each request gives
// exactly one result.
// ----------------------------------------------------------------------------
// Requests are taken one per clock while the request queue is not full: the front
// end updates the previous error and the saturating integral as it takes each
// request, and the back end pipeline (products, then term sum and squared error
// total) moves one request per clock as long as the result queue has room. Gains
// and the recording flag are written through the configuration channel, which is
// always ready; write them only while no request is in flight.
module pid_controller_step_top #(
    parameter int MID_DEPTH = 4,
    parameter int OUT_DEPTH = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [1:0]                          i_opcode,
    input  logic signed [pid_pkg::ERR_W-1:0]    i_error_sample,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [pid_pkg::DRIVE_W-1:0]  o_drive,
    output logic [pid_pkg::TOTAL_W-1:0]         o_total_squared_error,
    output logic                                o_saturated,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [1:0]                          i_cfg_index,
    input  logic [pid_pkg::GAIN_W-1:0]          i_cfg_data
);

    pid_pkg::t_cfg     r_cfg;
    pid_pkg::t_work    front_work;
    pid_pkg::t_work    back_work;
    pid_pkg::t_result  back_result;
    pid_pkg::t_result  out_result;
    logic              mid_push;
    logic              mid_full;
    logic              mid_pop;
    logic              mid_empty;
    logic              out_push;
    logic              out_full;

    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (pid_pkg::t_cfg_reg'(i_cfg_index))
                pid_pkg::CFG_KP:     r_cfg.kp     <= i_cfg_data;
                pid_pkg::CFG_KD:     r_cfg.kd     <= i_cfg_data;
                pid_pkg::CFG_KI:     r_cfg.ki     <= i_cfg_data;
                pid_pkg::CFG_RECORD: r_cfg.record <= i_cfg_data[0];
            endcase
        end
    end

    // Front end: takes requests and tracks the controller state.
    pid_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_opcode       (i_opcode),
        .i_error_sample (i_error_sample),
        .i_queue_full   (mid_full),
        .o_queue_push   (mid_push),
        .o_work         (front_work)
    );

    assign full = mid_full;

    // Queue between front and back end.
    pid_fifo #(
        .WIDTH ($bits(pid_pkg::t_work)),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mid_push),
        .i_wdata (front_work),
        .o_full  (mid_full),
        .i_pop   (mid_pop),
        .o_rdata (back_work),
        .o_empty (mid_empty)
    );

    // Back end: arithmetic pipeline.
    pid_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_work        (back_work),
        .i_queue_empty (mid_empty),
        .o_queue_pop   (mid_pop),
        .i_out_full    (out_full),
        .o_out_push    (out_push),
        .o_result      (back_result)
    );

    // Result queue.
    pid_fifo #(
        .WIDTH ($bits(pid_pkg::t_result)),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_wdata (back_result),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_rdata (out_result),
        .o_empty (empty)
    );

    assign o_drive               = out_result.drive;
    assign o_total_squared_error = out_result.total;
    assign o_saturated           = out_result.saturated;

endmodule

// ===== design/pid_chk.sv =====
// ----------------------------------------------------------------------------
// PID step port checker
// Watches the top level ports and checks request and result accounting.
// ----------------------------------------------------------------------------
module pid_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                push,
    input logic                                full,
    input logic                                empty,
    input logic                                pop,
    input logic signed [pid_pkg::DRIVE_W-1:0]  o_drive,
    input logic [pid_pkg::TOTAL_W-1:0]         o_total_squared_error,
    input logic                                o_saturated
);

    // Enough for queues plus pipeline at the default depths.
    localparam logic [7:0] MAX_INFLIGHT = 8'd12;

    logic [7:0] r_inflight;
    logic       in_take;
    logic       out_take;

    assign in_take  = push && !full;
    assign out_take = pop && !empty;

    // Requests taken but not yet delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else if (in_take && !out_take) begin
            r_inflight <= r_inflight + 1'b1;
        end else if (out_take && !in_take) begin
            r_inflight <= r_inflight - 1'b1;
        end
    end

    // Reset leaves both queues empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

    // No result appears without an outstanding request.
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_inflight == '0) |-> empty)
        else $error("result shown with no request in flight");

    // In-flight count stays within the storage of the block.
    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= MAX_INFLIGHT)
        else $error("more requests in flight than the block can hold");

    // A waiting result holds until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_drive)
            && $stable(o_total_squared_error) && $stable(o_saturated)))
        else $error("waiting result changed before it was taken");

endmodule

bind pid_controller_step_top pid_chk u_pid_chk (
    .i_clk                 (i_clk),
    .i_rst_n               (i_rst_n),
    .push                  (push),
    .full                  (full),
    .empty                 (empty),
    .pop                   (pop),
    .o_drive               (o_drive),
    .o_total_squared_error (o_total_squared_error),
    .o_saturated           (o_saturated)
);
